// ===== design/mcbf_pkg.sv =====
// shared types and constants for the multi-channel bounded fifo
package mcbf_pkg;

   // default sizing
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int CHAN_DEPTH_DEF   = 16;
   localparam int DATA_WIDTH_DEF   = 32;

   // fixed widths of the transaction fields
   localparam int REQ_W       = 3;
   localparam int IDX_W       = 4;
   localparam int DATA_PORT_W = 32;
   localparam int CAP_W       = 5;
   localparam int OPENED_W    = 3;

   typedef enum logic [REQ_W-1:0] {
      REQ_OPEN    = 3'd0,
      REQ_CLOSE   = 3'd1,
      REQ_SEND    = 3'd2,
      REQ_RECV    = 3'd3,
      REQ_BCAST   = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_CHANNEL   = 2'd1,
      STATUS_WOULD_BLOCK  = 2'd2,
      STATUS_NO_FREE_SLOT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_OPEN_SCAN,
      S_SEND_WR,
      S_RECV_POP,
      S_RECV_DATA,
      S_BC_RD,
      S_BC_CHK,
      S_BW_RD,
      S_BW_WR,
      S_DONE
   } state_type;

endpackage

// ===== design/multi_channel_bounded_fifo.sv =====
// multi-channel bounded fifo: channel table, shared message store and request sequencer
//
// A table of NUM_CHANNELS message channels, each a fifo of words with its own
// capacity limit, kept in one shared message store (one region of CHAN_DEPTH
// words per slot) and one per-slot context memory (limit, head, count). Each
// request transaction (open, close, send, receive, broadcast) gives exactly one
// response transaction. The block works on one transaction at a time under a
// small sequencer; req_stall is high from acceptance until the response is
// loaded into the output register, and a finished response may wait there
// while the next request is accepted. Receive does a context read, then a
// store read (no store read when the channel is empty); open makes a downward
// scan of the slot-open bits for the highest free slot; broadcast makes a
// check pass and a write pass over the slots in use, each step a registered
// context read then an update. The message store has no reset: a word is only
// ever read after it was written, and the context of a slot is only read while
// the slot is open, which open always initializes.
module multi_channel_bounded_fifo #(
   parameter int NUM_CHANNELS = mcbf_pkg::NUM_CHANNELS_DEF,
   parameter int CHAN_DEPTH   = mcbf_pkg::CHAN_DEPTH_DEF,
   parameter int DATA_WIDTH   = mcbf_pkg::DATA_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mcbf_pkg::REQ_W-1:0]       req_type,
   input  logic [mcbf_pkg::IDX_W-1:0]       req_chan_index,
   input  logic [mcbf_pkg::DATA_PORT_W-1:0] req_send_data,
   input  logic [mcbf_pkg::CAP_W-1:0]       req_capacity_limit,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [mcbf_pkg::DATA_PORT_W-1:0] rsp_recv_data,
   output logic [mcbf_pkg::OPENED_W-1:0]    rsp_opened_index
);

   // derived sizes
   localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SLOTS_W   = $clog2(NUM_CHANNELS + 1);
   localparam int HEAD_W    = (CHAN_DEPTH > 1) ? $clog2(CHAN_DEPTH) : 1;
   localparam int CNT_W     = $clog2(CHAN_DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int CTX_W     = CNT_W + HEAD_W + CNT_W;
   localparam int MSG_AW    = CH_W + HEAD_W;
   localparam int MSG_DEPTH = NUM_CHANNELS * (2 ** HEAD_W);

   // sequencer state
   mcbf_pkg::state_type state_ff, state_in;

   // captured request
   logic [mcbf_pkg::REQ_W-1:0]       req_code_ff, req_code_in;
   logic [CH_W-1:0]                  slot_ff, slot_in;
   logic                             chan_ok_ff, chan_ok_in;
   logic [mcbf_pkg::DATA_PORT_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0]                 limit_ff, limit_in;

   // scan pointer and broadcast flag
   logic [SLOTS_W-1:0] scan_ff, scan_in;
   logic               any_ff, any_in;

   // channel table
   logic [SLOTS_W-1:0]      slots_in_use_ff, slots_in_use_in;
   logic [NUM_CHANNELS-1:0] slot_open_ff, slot_open_in;

   // staged result
   mcbf_pkg::status_type             res_status_ff, res_status_in;
   logic [mcbf_pkg::DATA_PORT_W-1:0] res_data_ff, res_data_in;
   logic [mcbf_pkg::OPENED_W-1:0]    res_opened_ff, res_opened_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       rsp_status_ff, rsp_status_in;
   logic [mcbf_pkg::DATA_PORT_W-1:0] rsp_data_ff, rsp_data_in;
   logic [mcbf_pkg::OPENED_W-1:0]    rsp_opened_ff, rsp_opened_in;

   // per-slot context memory {limit, head, count}
   logic [CTX_W-1:0] ctx_mem [NUM_CHANNELS];
   logic [CTX_W-1:0] ctx_rdata_ff;
   logic             ctx_we;
   logic [CH_W-1:0]  ctx_waddr;
   logic [CTX_W-1:0] ctx_wdata;
   logic [CH_W-1:0]  ctx_raddr;

   // shared message store
   logic [DATA_WIDTH-1:0] msg_mem [MSG_DEPTH];
   logic [DATA_WIDTH-1:0] msg_rdata_ff;
   logic                  msg_we;
   logic [MSG_AW-1:0]     msg_waddr;
   logic [DATA_WIDTH-1:0] msg_wdata;
   logic [MSG_AW-1:0]     msg_raddr;

   // decode helpers
   logic [31:0]        idx_wide;
   logic [CNT_W-1:0]   rd_limit;
   logic [HEAD_W-1:0]  rd_head;
   logic [CNT_W-1:0]   rd_count;
   logic [SUM_W-1:0]   pos_sum;
   logic [SUM_W-1:0]   head_sum;
   logic [HEAD_W-1:0]  push_pos;
   logic [HEAD_W-1:0]  head_next;
   logic               ch_full;
   logic               usable;
   logic [CH_W-1:0]    scan_idx;
   logic [SLOTS_W-1:0] scan_dec;
   logic [CH_W-1:0]    pick;
   logic               bc_phase;
   logic [CH_W-1:0]    cur_slot;
   logic               rsp_load;

   assign req_stall        = (state_ff != mcbf_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_recv_data    = rsp_data_ff;
   assign rsp_opened_index = rsp_opened_ff;

   // context fields from the registered read
   assign rd_limit = ctx_rdata_ff[CTX_W-1 -: CNT_W];
   assign rd_head  = ctx_rdata_ff[CNT_W +: HEAD_W];
   assign rd_count = ctx_rdata_ff[CNT_W-1:0];
   assign ch_full  = (rd_count >= rd_limit);

   // wrap arithmetic: sums stay below twice the depth, so one compare-subtract
   assign pos_sum   = SUM_W'(rd_head) + SUM_W'(rd_count);
   assign push_pos  = (pos_sum >= SUM_W'(CHAN_DEPTH)) ?
                      HEAD_W'(pos_sum - SUM_W'(CHAN_DEPTH)) : HEAD_W'(pos_sum);
   assign head_sum  = SUM_W'(rd_head) + SUM_W'(1);
   assign head_next = (head_sum >= SUM_W'(CHAN_DEPTH)) ?
                      HEAD_W'(head_sum - SUM_W'(CHAN_DEPTH)) : HEAD_W'(head_sum);

   assign idx_wide = 32'(req_chan_index);
   assign usable   = chan_ok_ff && (SLOTS_W'(slot_ff) < slots_in_use_ff) &&
                     slot_open_ff[slot_ff];

   assign scan_idx = scan_ff[CH_W-1:0];
   assign scan_dec = scan_ff - SLOTS_W'(1);
   // open: highest free slot below the table length, else append
   assign pick     = (scan_ff == '0) ? slots_in_use_ff[CH_W-1:0] : scan_dec[CH_W-1:0];

   assign bc_phase = (state_ff == mcbf_pkg::S_BC_RD) || (state_ff == mcbf_pkg::S_BC_CHK) ||
                     (state_ff == mcbf_pkg::S_BW_RD) || (state_ff == mcbf_pkg::S_BW_WR);
   assign cur_slot = bc_phase ? scan_idx : slot_ff;

   // memory ports
   assign ctx_raddr = cur_slot;
   assign msg_waddr = {cur_slot, push_pos};
   assign msg_raddr = {slot_ff, rd_head};
   assign msg_wdata = DATA_WIDTH'(data_ff);

   // output register takes the staged result once the previous one is gone
   assign rsp_load = (state_ff == mcbf_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      req_code_in     = req_code_ff;
      slot_in         = slot_ff;
      chan_ok_in      = chan_ok_ff;
      data_in         = data_ff;
      limit_in        = limit_ff;
      scan_in         = scan_ff;
      any_in          = any_ff;
      slots_in_use_in = slots_in_use_ff;
      slot_open_in    = slot_open_ff;
      res_status_in   = res_status_ff;
      res_data_in     = res_data_ff;
      res_opened_in   = res_opened_ff;
      ctx_we          = 1'b0;
      ctx_waddr       = cur_slot;
      ctx_wdata       = {rd_limit, rd_head, rd_count + CNT_W'(1)};
      msg_we          = 1'b0;

      case (state_ff)
         mcbf_pkg::S_IDLE: begin
            if (req_valid) begin
               req_code_in = req_type;
               chan_ok_in  = (idx_wide < 32'(NUM_CHANNELS));
               slot_in     = idx_wide[CH_W-1:0];
               data_in     = req_send_data;
               // saturate the requested capacity at the region size
               limit_in    = (32'(req_capacity_limit) > 32'(CHAN_DEPTH)) ?
                             CNT_W'(CHAN_DEPTH) : CNT_W'(req_capacity_limit);
               state_in    = mcbf_pkg::S_DISPATCH;
            end
         end

         mcbf_pkg::S_DISPATCH: begin
            res_status_in = mcbf_pkg::STATUS_NO_CHANNEL;
            res_data_in   = '0;
            res_opened_in = '0;
            state_in      = mcbf_pkg::S_DONE;
            case (req_code_ff)
               mcbf_pkg::REQ_OPEN: begin
                  scan_in  = slots_in_use_ff;
                  state_in = mcbf_pkg::S_OPEN_SCAN;
               end
               mcbf_pkg::REQ_CLOSE: begin
                  if (usable) begin
                     slot_open_in[slot_ff] = 1'b0;
                     res_status_in         = mcbf_pkg::STATUS_OK;
                  end
               end
               mcbf_pkg::REQ_SEND: begin
                  if (usable) begin
                     state_in = mcbf_pkg::S_SEND_WR;
                  end
               end
               mcbf_pkg::REQ_RECV: begin
                  if (usable) begin
                     state_in = mcbf_pkg::S_RECV_POP;
                  end
               end
               mcbf_pkg::REQ_BCAST: begin
                  scan_in  = '0;
                  any_in   = 1'b0;
                  state_in = mcbf_pkg::S_BC_RD;
               end
               default: begin
                  state_in = mcbf_pkg::S_DONE;
               end
            endcase
         end

         mcbf_pkg::S_OPEN_SCAN: begin
            if ((scan_ff != '0) && slot_open_ff[scan_dec[CH_W-1:0]]) begin
               scan_in = scan_dec;
            end else if ((scan_ff == '0) &&
                         (slots_in_use_ff >= SLOTS_W'(NUM_CHANNELS))) begin
               res_status_in = mcbf_pkg::STATUS_NO_FREE_SLOT;
               state_in      = mcbf_pkg::S_DONE;
            end else begin
               if (scan_ff == '0) begin
                  slots_in_use_in = slots_in_use_ff + SLOTS_W'(1);
               end
               slot_open_in[pick] = 1'b1;
               ctx_we             = 1'b1;
               ctx_waddr          = pick;
               ctx_wdata          = {limit_ff, HEAD_W'(0), CNT_W'(0)};
               res_status_in      = mcbf_pkg::STATUS_OK;
               res_opened_in      = mcbf_pkg::OPENED_W'(pick);
               state_in           = mcbf_pkg::S_DONE;
            end
         end

         mcbf_pkg::S_SEND_WR: begin
            if (ch_full) begin
               res_status_in = mcbf_pkg::STATUS_WOULD_BLOCK;
            end else begin
               msg_we        = 1'b1;
               ctx_we        = 1'b1;
               res_status_in = mcbf_pkg::STATUS_OK;
            end
            state_in = mcbf_pkg::S_DONE;
         end

         mcbf_pkg::S_RECV_POP: begin
            if (rd_count == '0) begin
               res_status_in = mcbf_pkg::STATUS_WOULD_BLOCK;
               state_in      = mcbf_pkg::S_DONE;
            end else begin
               ctx_we        = 1'b1;
               ctx_wdata     = {rd_limit, head_next, rd_count - CNT_W'(1)};
               res_status_in = mcbf_pkg::STATUS_OK;
               state_in      = mcbf_pkg::S_RECV_DATA;
            end
         end

         mcbf_pkg::S_RECV_DATA: begin
            res_data_in = mcbf_pkg::DATA_PORT_W'(msg_rdata_ff);
            state_in    = mcbf_pkg::S_DONE;
         end

         // broadcast check pass: any open channel full blocks the whole broadcast
         mcbf_pkg::S_BC_RD: begin
            if (scan_ff == slots_in_use_ff) begin
               if (any_ff) begin
                  scan_in  = '0;
                  state_in = mcbf_pkg::S_BW_RD;
               end else begin
                  state_in = mcbf_pkg::S_DONE;
               end
            end else begin
               state_in = mcbf_pkg::S_BC_CHK;
            end
         end

         mcbf_pkg::S_BC_CHK: begin
            if (slot_open_ff[scan_idx] && ch_full) begin
               res_status_in = mcbf_pkg::STATUS_WOULD_BLOCK;
               state_in      = mcbf_pkg::S_DONE;
            end else begin
               if (slot_open_ff[scan_idx]) begin
                  any_in = 1'b1;
               end
               scan_in  = scan_ff + SLOTS_W'(1);
               state_in = mcbf_pkg::S_BC_RD;
            end
         end

         // broadcast write pass
         mcbf_pkg::S_BW_RD: begin
            if (scan_ff == slots_in_use_ff) begin
               res_status_in = mcbf_pkg::STATUS_OK;
               state_in      = mcbf_pkg::S_DONE;
            end else begin
               state_in = mcbf_pkg::S_BW_WR;
            end
         end

         mcbf_pkg::S_BW_WR: begin
            if (slot_open_ff[scan_idx]) begin
               msg_we = 1'b1;
               ctx_we = 1'b1;
            end
            scan_in  = scan_ff + SLOTS_W'(1);
            state_in = mcbf_pkg::S_BW_RD;
         end

         mcbf_pkg::S_DONE: begin
            if (rsp_load) begin
               state_in = mcbf_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mcbf_pkg::S_IDLE;
         end
      endcase
   end

   // response output register
   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_opened_in = rsp_opened_ff;
      if (rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_data_ff;
         rsp_opened_in = res_opened_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mcbf_pkg::S_IDLE;
         slots_in_use_ff <= '0;
         slot_open_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         slots_in_use_ff <= slots_in_use_in;
         slot_open_ff    <= slot_open_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_code_ff   <= req_code_in;
      slot_ff       <= slot_in;
      chan_ok_ff    <= chan_ok_in;
      data_ff       <= data_in;
      limit_ff      <= limit_in;
      scan_ff       <= scan_in;
      any_ff        <= any_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_opened_ff <= res_opened_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_opened_ff <= rsp_opened_in;
   end

   // context memory, registered read
   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_mem[ctx_waddr] <= ctx_wdata;
      end
      ctx_rdata_ff <= ctx_mem[ctx_raddr];
   end

   // message store, registered read
   always_ff @(posedge clock) begin
      if (msg_we) begin
         msg_mem[msg_waddr] <= msg_wdata;
      end
      msg_rdata_ff <= msg_mem[msg_raddr];
   end

endmodule

// ===== bench/multi_channel_bounded_fifo_test.sv =====
// self-checking testbench for the multi-channel bounded fifo
`timescale 1ns / 1ps

module multi_channel_bounded_fifo_test;

   // sizing of the block under test (defaults of the package)
   localparam int NUM_CH   = mcbf_pkg::NUM_CHANNELS_DEF;
   localparam int CH_DEPTH = mcbf_pkg::CHAN_DEPTH_DEF;

   // field widths
   localparam int REQ_W       = mcbf_pkg::REQ_W;
   localparam int IDX_W       = mcbf_pkg::IDX_W;
   localparam int DATA_PORT_W = mcbf_pkg::DATA_PORT_W;
   localparam int CAP_W       = mcbf_pkg::CAP_W;
   localparam int OPENED_W    = mcbf_pkg::OPENED_W;

   // request codes past broadcast are undefined and must answer no_channel
   localparam logic [REQ_W-1:0] REQ_UNDEFINED_FIRST = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNDEFINED_LAST  = 3'd7;

   // run control
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction at all
   localparam int PRESSURE_HOLD   = 300;   // long receiver hold-off
   localparam int DRAIN_CYCLES    = 60;
   localparam int MAX_REPORTED    = 10;

   typedef struct packed {
      mcbf_pkg::status_type       status;
      logic [DATA_PORT_W-1:0]     recv_data;
      logic [OPENED_W-1:0]        opened_index;
   } response_type;

   // channel table tracker: keeps its own copy of the slot table and the
   // message words, predicts the response of every accepted request and
   // compares the responses in order
   class channel_table;
      bit                     chan_open  [NUM_CH];
      int unsigned            slots_used;
      bit [CAP_W-1:0]         chan_limit [NUM_CH];
      bit [IDX_W-1:0]         chan_head  [NUM_CH];
      bit [CAP_W-1:0]         chan_count [NUM_CH];
      bit [DATA_PORT_W-1:0]   word_store [NUM_CH][CH_DEPTH];
      response_type           expected_responses[$];
      int                     mismatch_count;

      function bit usable(logic [IDX_W-1:0] idx);
         return (idx < slots_used) && chan_open[idx];
      endfunction

      function void push_word(int s, logic [DATA_PORT_W-1:0] word);
         int pos;
         pos = (chan_head[s] + chan_count[s]) % CH_DEPTH;
         word_store[s][pos] = word;
         chan_count[s] += 1;
      endfunction

      // next state of the table and the response for one request
      function response_type predict(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                     logic [DATA_PORT_W-1:0] word, logic [CAP_W-1:0] cap);
         response_type r;
         int pick;
         bit found, any_open, blocked;
         r.status       = mcbf_pkg::STATUS_NO_CHANNEL;
         r.recv_data    = '0;
         r.opened_index = '0;
         case (kind)
            mcbf_pkg::REQ_OPEN: begin
               found = 1'b0;
               pick  = 0;
               // highest free slot among those used so far
               for (int i = 0; i < slots_used; i++)
                  if (!chan_open[i]) begin
                     pick  = i;
                     found = 1'b1;
                  end
               if (!found && slots_used < NUM_CH) begin
                  pick = slots_used;
                  slots_used++;
                  found = 1'b1;
               end
               if (found) begin
                  chan_open[pick]  = 1'b1;
                  chan_limit[pick] = (cap > CH_DEPTH) ? CAP_W'(CH_DEPTH) : cap;
                  chan_head[pick]  = '0;
                  chan_count[pick] = '0;
                  r.opened_index   = OPENED_W'(pick);
                  r.status         = mcbf_pkg::STATUS_OK;
               end else begin
                  r.status = mcbf_pkg::STATUS_NO_FREE_SLOT;
               end
            end
            mcbf_pkg::REQ_CLOSE: begin
               if (usable(idx)) begin
                  chan_open[idx]  = 1'b0;
                  chan_head[idx]  = '0;
                  chan_count[idx] = '0;
                  r.status        = mcbf_pkg::STATUS_OK;
               end
            end
            mcbf_pkg::REQ_SEND: begin
               if (usable(idx)) begin
                  if (chan_count[idx] >= chan_limit[idx]) begin
                     r.status = mcbf_pkg::STATUS_WOULD_BLOCK;
                  end else begin
                     push_word(idx, word);
                     r.status = mcbf_pkg::STATUS_OK;
                  end
               end
            end
            mcbf_pkg::REQ_RECV: begin
               if (usable(idx)) begin
                  if (chan_count[idx] == 0) begin
                     r.status = mcbf_pkg::STATUS_WOULD_BLOCK;
                  end else begin
                     r.recv_data     = word_store[idx][chan_head[idx]];
                     chan_head[idx]  = IDX_W'((chan_head[idx] + 1) % CH_DEPTH);
                     chan_count[idx] -= 1;
                     r.status        = mcbf_pkg::STATUS_OK;
                  end
               end
            end
            mcbf_pkg::REQ_BCAST: begin
               any_open = 1'b0;
               blocked  = 1'b0;
               for (int i = 0; i < slots_used; i++)
                  if (chan_open[i]) begin
                     any_open = 1'b1;
                     if (chan_count[i] >= chan_limit[i])
                        blocked = 1'b1;
                  end
               if (blocked) begin
                  r.status = mcbf_pkg::STATUS_WOULD_BLOCK;
               end else if (any_open) begin
                  for (int i = 0; i < slots_used; i++)
                     if (chan_open[i])
                        push_word(i, word);
                  r.status = mcbf_pkg::STATUS_OK;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                 logic [DATA_PORT_W-1:0] word, logic [CAP_W-1:0] cap);
         expected_responses = {expected_responses, predict(kind, idx, word, cap)};
      endfunction

      function void note_mismatch(string what, longint unsigned want, longint unsigned got);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTED)
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      endfunction

      function void check_response(logic [1:0] status, logic [DATA_PORT_W-1:0] recv_data,
                                   logic [OPENED_W-1:0] opened_index);
         response_type want;
         if (expected_responses.size() == 0) begin
            note_mismatch("response with no request outstanding, status", 0, status);
            return;
         end
         want = expected_responses.pop_front();
         if (status !== want.status)
            note_mismatch("status", want.status, status);
         if (recv_data !== want.recv_data)
            note_mismatch("recv_data", want.recv_data, recv_data);
         if (opened_index !== want.opened_index)
            note_mismatch("opened_index", want.opened_index, opened_index);
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function int failures();
         return mismatch_count + expected_responses.size();
      endfunction
   endclass

   // clock, reset and block ports; every input known from time zero
   logic                    clock              = 1'b0;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic                    req_stall;
   logic [REQ_W-1:0]        req_type           = '0;
   logic [IDX_W-1:0]        req_chan_index     = '0;
   logic [DATA_PORT_W-1:0]  req_send_data      = '0;
   logic [CAP_W-1:0]        req_capacity_limit = '0;
   logic                    rsp_valid;
   logic                    rsp_stall          = 1'b0;
   logic [1:0]              rsp_status;
   logic [DATA_PORT_W-1:0]  rsp_recv_data;
   logic [OPENED_W-1:0]     rsp_opened_index;

   channel_table tracker = new;

   // traffic shaping, set by the stimulus between transactions
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request  = 0;   // asks the receiver for a long hold-off
   int hold_left     = 0;
   int idle_cycles   = 0;

   multi_channel_bounded_fifo uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_chan_index     (req_chan_index),
      .req_send_data      (req_send_data),
      .req_capacity_limit (req_capacity_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_recv_data      (rsp_recv_data),
      .rsp_opened_index   (rsp_opened_index)
   );

   always #10 clock = ~clock;

   // receiver: random stall at the falling edge, or a counted hold-off when
   // the stimulus asks for back pressure
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // response monitor: every accepted response goes to the tracker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_status, rsp_recv_data, rsp_opened_index);
   end

   // watchdog on cycles without any transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one request: random idle gaps first (payload scrambled while
   // valid is low), then hold the payload until the block takes it
   task automatic offer_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                logic [DATA_PORT_W-1:0] word, logic [CAP_W-1:0] cap);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid          <= 1'b0;
         req_type           <= REQ_W'($urandom);
         req_chan_index     <= IDX_W'($urandom);
         req_send_data      <= $urandom;
         req_capacity_limit <= CAP_W'($urandom);
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_chan_index     <= idx;
      req_send_data      <= word;
      req_capacity_limit <= cap;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      tracker.note_request(kind, idx, word, cap);
   endtask

   // random request mix: mostly sends and receives on real slots, with
   // enough opens and closes to keep the table churning, some broadcasts,
   // out-of-range indexes and undefined codes as noise
   task automatic offer_random_request();
      int roll;
      logic [REQ_W-1:0] kind;
      logic [IDX_W-1:0] idx;
      logic [CAP_W-1:0] cap;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         kind = mcbf_pkg::REQ_OPEN;
      else if (roll < 17)
         kind = mcbf_pkg::REQ_CLOSE;
      else if (roll < 50)
         kind = mcbf_pkg::REQ_SEND;
      else if (roll < 83)
         kind = mcbf_pkg::REQ_RECV;
      else if (roll < 96)
         kind = mcbf_pkg::REQ_BCAST;
      else
         kind = REQ_W'($urandom_range(REQ_UNDEFINED_FIRST, REQ_UNDEFINED_LAST));
      if ($urandom_range(0, 99) < 88)
         idx = IDX_W'($urandom_range(0, NUM_CH - 1));
      else
         idx = IDX_W'($urandom_range(NUM_CH, (1 << IDX_W) - 1));
      // capacities mostly in the legal range, sometimes zero or oversized
      if ($urandom_range(0, 9) == 0)
         cap = CAP_W'($urandom_range(0, (1 << CAP_W) - 1));
      else
         cap = CAP_W'($urandom_range(1, CH_DEPTH));
      offer_request(kind, idx, $urandom, cap);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count)
         offer_random_request();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table first
      offer_request(mcbf_pkg::REQ_RECV, 0, 32'h0, 0);             // nothing open
      offer_request(mcbf_pkg::REQ_CLOSE, 15, 32'hFFFF_FFFF, 31);  // index past the table
      offer_request(mcbf_pkg::REQ_BCAST, 0, 32'hA5A5_5A5A, 0);    // broadcast, nothing open
      for (int k = REQ_UNDEFINED_FIRST; k <= REQ_UNDEFINED_LAST; k++)
         offer_request(REQ_W'(k), 0, 32'h0, 0);                   // undefined codes
      offer_request(mcbf_pkg::REQ_OPEN, 0, 32'h0, 0);             // slot 0, zero capacity
      offer_request(mcbf_pkg::REQ_SEND, 0, 32'h1234_5678, 0);     // always full
      offer_request(mcbf_pkg::REQ_OPEN, 0, 32'h0, 31);            // slot 1, saturated
      offer_request(mcbf_pkg::REQ_OPEN, 0, 32'h0, 16);            // slot 2, full depth
      offer_request(mcbf_pkg::REQ_OPEN, 0, 32'h0, 1);             // slot 3, one word
      offer_request(mcbf_pkg::REQ_BCAST, 0, 32'hFFFF_FFFF, 0);    // blocked by slot 0
      offer_request(mcbf_pkg::REQ_CLOSE, 0, 32'h0, 0);
      offer_request(mcbf_pkg::REQ_CLOSE, 0, 32'h0, 0);            // already closed
      offer_request(mcbf_pkg::REQ_BCAST, 0, 32'hFFFF_FFFF, 0);    // reaches slots 1..3
      offer_request(mcbf_pkg::REQ_BCAST, 0, 32'h0, 0);            // slot 3 now full
      offer_request(mcbf_pkg::REQ_RECV, 3, 32'h0, 0);
      offer_request(mcbf_pkg::REQ_RECV, 3, 32'h0, 0);             // empty again
      offer_request(mcbf_pkg::REQ_SEND, 1, 32'h0, 0);
      offer_request(mcbf_pkg::REQ_RECV, 1, 32'h0, 0);
      offer_request(mcbf_pkg::REQ_OPEN, 0, 32'h0, 5);             // reuses slot 0
      offer_request(mcbf_pkg::REQ_SEND, 9, 32'h0, 0);             // above slots in use
      repeat (4)
         offer_request(mcbf_pkg::REQ_OPEN, 0, 32'h0, 2);          // fills slots 4..7
      offer_request(mcbf_pkg::REQ_OPEN, 0, 32'h0, 2);             // table full

      // random traffic under the different idling patterns
      run_phase(0, 0, 300);
      run_phase(71, 0, 300);
      run_phase(0, 71, 300);
      run_phase(10, 10, 300);

      // back pressure: receiver holds off while requests keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = PRESSURE_HOLD;
      repeat (60)
         offer_random_request();

      run_phase(0, 0, 140);

      // drain
      @(negedge clock);
      req_valid     <= 1'b0;
      rsp_stall_pct = 0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      if (tracker.failures() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
design/mcbf_pkg.sv
design/multi_channel_bounded_fifo.sv
bench/multi_channel_bounded_fifo_test.sv
